// ----- hdl/hrhf_pkg.sv -----
// ----------------------------------------------------------------------------
// hrhf_pkg
// Shared types, codes and constants of the HTTP request framer.
// ----------------------------------------------------------------------------
package hrhf_pkg;

  localparam int unsigned LENGTH_BITS_DEF    = 16;
  localparam int unsigned TAIL_WINDOW_BITS   = 64;
  localparam int unsigned PREFIX_LEN         = 7;
  localparam int unsigned PREFIX_LEN_COUNTED = 6;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [TAIL_WINDOW_BITS-1:0] CLOSE_TAG = 64'h3C2F_6874_6D6C_3E0A;

  // byte_class codes
  localparam logic [1:0] CLS_HEADER  = 2'd0;
  localparam logic [1:0] CLS_PREFIX  = 2'd1;
  localparam logic [1:0] CLS_BODY    = 2'd2;
  localparam logic [1:0] CLS_OUTSIDE = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PREFIX = 2'd1,
    PH_BODY   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] cr_count;
    logic [1:0] lf_count;
    logic [2:0] prefix_index;
    logic       body_flag;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] byte_class;
    logic       frame_complete;
    logic       verdict_valid;
    logic       parse_ok;
    logic       body_present;
  } res_t;

  // "<html>\n", one character per index
  function automatic logic [7:0] open_tag_byte(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h3C;
      3'd1:    ch = 8'h68;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h6D;
      3'd4:    ch = 8'h6C;
      3'd5:    ch = 8'h3E;
      3'd6:    ch = 8'h0A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- hdl/hrhf_step.sv -----
// ----------------------------------------------------------------------------
// hrhf_step
// Per-byte next-state and result logic of the request framer.
// ----------------------------------------------------------------------------
module hrhf_step import hrhf_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic [7:0]                  data_byte_i,
  input  logic                        buffer_end_i,
  input  ctrl_t                       ctrl_i,
  input  logic [LENGTH_BITS-1:0]      hdr_i,
  input  logic [LENGTH_BITS-1:0]      body_i,
  input  logic [TAIL_WINDOW_BITS-1:0] win_i,
  output ctrl_t                       ctrl_o,
  output logic [LENGTH_BITS-1:0]      hdr_o,
  output logic [LENGTH_BITS-1:0]      body_o,
  output logic [TAIL_WINDOW_BITS-1:0] win_o,
  output res_t                        res_o,
  output logic [LENGTH_BITS-1:0]      length_o
);

  localparam int unsigned SUM_BITS = LENGTH_BITS + 2;

  ctrl_t                       ctrl_n;
  logic [LENGTH_BITS-1:0]      hdr_n;
  logic [LENGTH_BITS-1:0]      body_n;
  logic [TAIL_WINDOW_BITS-1:0] win_n;
  logic [SUM_BITS-1:0]         len_sum;
  res_t                        res;

  always_comb begin
    ctrl_n             = ctrl_i;
    hdr_n              = hdr_i;
    body_n             = body_i;
    win_n              = win_i;
    res.byte_class     = CLS_OUTSIDE;
    res.frame_complete = 1'b0;

    unique case (ctrl_i.phase)
      PH_HEADER: begin
        res.byte_class = CLS_HEADER;
        hdr_n = (&hdr_i) ? hdr_i : hdr_i + 1'b1;
        if (data_byte_i == CHAR_CR) begin
          if (ctrl_i.lf_count <= 2'd1 && ctrl_i.cr_count != 2'd3) begin
            ctrl_n.cr_count = ctrl_i.cr_count + 2'd1;
          end
        end else if (data_byte_i == CHAR_LF) begin
          if ((ctrl_i.cr_count == 2'd1 || ctrl_i.cr_count == 2'd2) &&
              ctrl_i.lf_count != 2'd3) begin
            ctrl_n.lf_count = ctrl_i.lf_count + 2'd1;
          end
        end else begin
          ctrl_n.cr_count = 2'd0;
          ctrl_n.lf_count = 2'd0;
        end
        if (ctrl_n.cr_count == 2'd2 && ctrl_n.lf_count == 2'd2) begin
          ctrl_n.phase        = PH_PREFIX;
          ctrl_n.prefix_index = 3'd0;
        end
      end
      PH_PREFIX: begin
        if (ctrl_i.prefix_index != 3'(PREFIX_LEN) &&
            data_byte_i == open_tag_byte(ctrl_i.prefix_index)) begin
          res.byte_class      = CLS_PREFIX;
          ctrl_n.prefix_index = ctrl_i.prefix_index + 3'd1;
          if (ctrl_i.prefix_index == 3'(PREFIX_LEN - 1)) begin
            ctrl_n.body_flag = 1'b1;
            ctrl_n.phase     = PH_BODY;
            win_n            = '0;
          end
        end else begin
          // mismatch: request ends here without a body
          res.frame_complete = 1'b1;
          ctrl_n.phase       = PH_DONE;
        end
      end
      PH_BODY: begin
        res.byte_class = CLS_BODY;
        body_n = (&body_i) ? body_i : body_i + 1'b1;
        win_n  = {win_i[TAIL_WINDOW_BITS-9:0], data_byte_i};
        if (win_n == CLOSE_TAG) begin
          res.frame_complete = 1'b1;
          ctrl_n.phase       = PH_DONE;
        end
      end
      PH_DONE: begin
        res.byte_class = CLS_OUTSIDE;
      end
      default: begin
        res.byte_class = CLS_OUTSIDE;
      end
    endcase

    len_sum = SUM_BITS'(hdr_n);
    if (ctrl_n.body_flag) begin
      len_sum = len_sum + SUM_BITS'(body_n) + SUM_BITS'(PREFIX_LEN_COUNTED);
    end

    res.verdict_valid = buffer_end_i;
    res.parse_ok      = 1'b0;
    res.body_present  = 1'b0;
    length_o          = '0;
    ctrl_o            = ctrl_n;
    hdr_o             = hdr_n;
    body_o            = body_n;
    win_o             = win_n;

    if (buffer_end_i) begin
      if (ctrl_n.phase == PH_PREFIX) begin
        res.frame_complete = 1'b1;
      end
      res.parse_ok     = (ctrl_n.phase == PH_PREFIX) || (ctrl_n.phase == PH_DONE);
      res.body_present = ctrl_n.body_flag;
      length_o = (|len_sum[SUM_BITS-1:LENGTH_BITS]) ? '1 : len_sum[LENGTH_BITS-1:0];
      // back to the idle header state for the next buffer
      ctrl_o.phase        = PH_HEADER;
      ctrl_o.cr_count     = 2'd0;
      ctrl_o.lf_count     = 2'd0;
      ctrl_o.prefix_index = 3'd0;
      ctrl_o.body_flag    = 1'b0;
      hdr_o               = '0;
      body_o              = '0;
      win_o               = '0;
    end
  end

  assign res_o = res;

endmodule

// ----- hdl/http_request_html_framer_core.sv -----
// ----------------------------------------------------------------------------
// http_request_html_framer_core
// Byte-serial HTTP request framer with html body delimiting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one request byte per beat (data_byte_i, buffer_end_i with
//   the last byte of a buffer flagged), handshake in_valid_i / in_stall_o.
//   Output channel: exactly one result beat per input beat, handshake
//   out_valid_o / out_stall_i, carrying the byte class and, on the last
//   byte, the verdict (parse_ok, body_present, request_length).
//   The result of a byte accepted at a clock edge is shown from the next
//   cycle on. Throughput is one byte per cycle while the receiver does not
//   stall a full result register, set by the state update of the
//   header/prefix/body tracker followed by one output register.
//   When the receiver stalls while the result register is full, it holds and
//   in_stall_o is raised in the same cycle, so no byte is accepted until it drains.
//   Reset clears the tracker to the header phase and empties the output
//   register; a buffer's last byte also returns the tracker to that state.
// ----------------------------------------------------------------------------
module http_request_html_framer_core import hrhf_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   buffer_end_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             byte_class_o,
  output logic                   frame_complete_o,
  output logic                   verdict_valid_o,
  output logic                   parse_ok_o,
  output logic                   body_present_o,
  output logic [LENGTH_BITS-1:0] request_length_o
);

  ctrl_t                       ctrl_q, ctrl_d;
  logic [LENGTH_BITS-1:0]      hdr_q, hdr_d;
  logic [LENGTH_BITS-1:0]      body_q, body_d;
  logic [TAIL_WINDOW_BITS-1:0] win_q, win_d;
  res_t                        res_q, res_d;
  logic [LENGTH_BITS-1:0]      len_q, len_d;
  logic                        out_valid_q;
  logic                        accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  hrhf_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .data_byte_i (data_byte_i),
    .buffer_end_i(buffer_end_i),
    .ctrl_i      (ctrl_q),
    .hdr_i       (hdr_q),
    .body_i      (body_q),
    .win_i       (win_q),
    .ctrl_o      (ctrl_d),
    .hdr_o       (hdr_d),
    .body_o      (body_d),
    .win_o       (win_d),
    .res_o       (res_d),
    .length_o    (len_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '{phase: PH_HEADER, cr_count: 2'd0, lf_count: 2'd0,
                  prefix_index: 3'd0, body_flag: 1'b0};
      hdr_q  <= '0;
      body_q <= '0;
      win_q  <= '0;
    end else if (accept) begin
      ctrl_q <= ctrl_d;
      hdr_q  <= hdr_d;
      body_q <= body_d;
      win_q  <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
      len_q <= len_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_class_o     = res_q.byte_class;
  assign frame_complete_o = res_q.frame_complete;
  assign verdict_valid_o  = res_q.verdict_valid;
  assign parse_ok_o       = res_q.parse_ok;
  assign body_present_o   = res_q.body_present;
  assign request_length_o = len_q;

endmodule

// ----- hdl/hrhf_checker.sv -----
// ----------------------------------------------------------------------------
// hrhf_checker
// Port-level assertions for the request framer, bound to the top level.
// ----------------------------------------------------------------------------
module hrhf_checker import hrhf_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [1:0]             byte_class_o,
  input logic                   frame_complete_o,
  input logic                   verdict_valid_o,
  input logic                   parse_ok_o,
  input logic                   body_present_o,
  input logic [LENGTH_BITS-1:0] request_length_o
);

  // a full, stalled result register must push back on the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input not stalled while result beat is held");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_class_o) &&
      $stable(frame_complete_o) && $stable(verdict_valid_o) &&
      $stable(parse_ok_o) && $stable(body_present_o) && $stable(request_length_o))
    else $error("stalled result beat changed");

  a_no_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !verdict_valid_o |->
      !parse_ok_o && !body_present_o && request_length_o == '0)
    else $error("verdict fields set without verdict");

  a_fail_not_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_valid_o && !parse_ok_o |-> !frame_complete_o)
    else $error("failed request flagged complete");

  // mid-buffer completion happens only on a body close or a prefix mismatch
  a_complete_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_complete_o && !verdict_valid_o |->
      byte_class_o == CLS_BODY || byte_class_o == CLS_OUTSIDE)
    else $error("completion on unexpected byte class");

endmodule

bind http_request_html_framer_core hrhf_checker #(
  .LENGTH_BITS(LENGTH_BITS)
) u_hrhf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .byte_class_o    (byte_class_o),
  .frame_complete_o(frame_complete_o),
  .verdict_valid_o (verdict_valid_o),
  .parse_ok_o      (parse_ok_o),
  .body_present_o  (body_present_o),
  .request_length_o(request_length_o)
);

// ----- tb/sv/http_request_html_framer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_html_framer_core testbench
// Feeds request buffers byte by byte: a short directed table, a burst under a
// long receiver hold-off, then random requests (mostly well formed, some
// noise and truncation) under four idle/stall mixes. Every result beat is
// checked field by field against a cycle-free tracker kept in this file.
// ----------------------------------------------------------------------------
module testbench;
  import hrhf_pkg::*;

  localparam int unsigned LEN_W          = LENGTH_BITS_DEF;
  localparam logic [31:0] LEN_MAX        = (32'd1 << LEN_W) - 32'd1;
  localparam logic [55:0] HTML_OPEN      = 56'h3C_6874_6D6C_3E0A;
  localparam int unsigned DIR_ROW_COUNT  = 25;
  localparam int unsigned PHASE_ITEMS    = 125;
  localparam int unsigned HOLD_ITEMS     = 30;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]       byte_class;
    logic             frame_complete;
    logic             verdict_valid;
    logic             parse_ok;
    logic             body_present;
    logic [LEN_W-1:0] request_length;
  } beat_res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    beat_res_t  res;
  } dir_row_t;

  localparam beat_res_t NO_RES = '0;

  // Directed table: a one-byte buffer, a buffer ending right after the
  // header, then a full request with body, close tag and a trailing byte.
  localparam dir_row_t DIR_ROWS [DIR_ROW_COUNT] = '{
    '{8'h00, 1'b1, 1'b1, '{CLS_HEADER, 1'b0, 1'b1, 1'b0, 1'b0, 16'd1}},
    '{8'h0D, 1'b0, 1'b0, NO_RES},
    '{8'h0A, 1'b0, 1'b0, NO_RES},
    '{8'h0D, 1'b0, 1'b0, NO_RES},
    '{8'h0A, 1'b1, 1'b1, '{CLS_HEADER, 1'b1, 1'b1, 1'b1, 1'b0, 16'd4}},
    '{8'h0D, 1'b0, 1'b0, NO_RES},
    '{8'h0A, 1'b0, 1'b0, NO_RES},
    '{8'h0D, 1'b0, 1'b0, NO_RES},
    '{8'h0A, 1'b0, 1'b0, NO_RES},
    '{8'h3C, 1'b0, 1'b0, NO_RES},
    '{8'h68, 1'b0, 1'b0, NO_RES},
    '{8'h74, 1'b0, 1'b0, NO_RES},
    '{8'h6D, 1'b0, 1'b0, NO_RES},
    '{8'h6C, 1'b0, 1'b0, NO_RES},
    '{8'h3E, 1'b0, 1'b0, NO_RES},
    '{8'h0A, 1'b0, 1'b0, NO_RES},
    '{8'h3C, 1'b0, 1'b0, NO_RES},
    '{8'h2F, 1'b0, 1'b0, NO_RES},
    '{8'h68, 1'b0, 1'b0, NO_RES},
    '{8'h74, 1'b0, 1'b0, NO_RES},
    '{8'h6D, 1'b0, 1'b0, NO_RES},
    '{8'h6C, 1'b0, 1'b0, NO_RES},
    '{8'h3E, 1'b0, 1'b0, NO_RES},
    '{8'h0A, 1'b0, 1'b1, '{CLS_BODY, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0}},
    '{8'hFF, 1'b1, 1'b1, '{CLS_OUTSIDE, 1'b0, 1'b1, 1'b1, 1'b1, 16'd18}}
  };

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic [7:0]       data_byte  = 8'h00;
  logic             buffer_end = 1'b0;
  logic             out_stall  = 1'b0;
  logic             row_typed  = 1'b0;
  beat_res_t        row_res    = '0;
  logic             in_stall;
  logic             out_valid;
  logic [1:0]       byte_class;
  logic             frame_complete;
  logic             verdict_valid;
  logic             parse_ok;
  logic             body_present;
  logic [LEN_W-1:0] request_length;

  // tracker copy of the framer state
  phase_e      trk_phase    = PH_HEADER;
  logic [1:0]  trk_cr       = '0;
  logic [1:0]  trk_lf       = '0;
  logic [2:0]  trk_pfx_idx  = '0;
  logic [63:0] trk_window   = '0;
  logic [31:0] trk_hdr_len  = '0;
  logic [31:0] trk_body_len = '0;
  logic        trk_body     = 1'b0;

  beat_res_t   pending_results [$];
  logic [7:0]  req_buf [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_ack       = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned error_count    = 0;
  int unsigned beats_sent     = 0;
  int unsigned requests_sent  = 0;
  int unsigned beats_checked  = 0;
  int unsigned verdicts_seen  = 0;
  int unsigned verdicts_ok    = 0;
  int unsigned verdicts_body  = 0;

  http_request_html_framer_core DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .buffer_end_i     (buffer_end),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .byte_class_o     (byte_class),
    .frame_complete_o (frame_complete),
    .verdict_valid_o  (verdict_valid),
    .parse_ok_o       (parse_ok),
    .body_present_o   (body_present),
    .request_length_o (request_length)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] open_char(input int unsigned idx);
    return HTML_OPEN[8*(6-idx) +: 8];
  endfunction

  function automatic logic [7:0] close_char(input int unsigned idx);
    return CLOSE_TAG[8*(7-idx) +: 8];
  endfunction

  function automatic logic [31:0] bump_len(input logic [31:0] v);
    return (v >= LEN_MAX) ? LEN_MAX : v + 32'd1;
  endfunction

  // Advances the tracker by one byte and returns the result beat it causes.
  function automatic beat_res_t frame_tracker_step(input logic [7:0] b, input logic last);
    beat_res_t   r;
    logic [31:0] total;
    r = '0;
    r.byte_class = CLS_OUTSIDE;
    case (trk_phase)
      PH_HEADER: begin
        r.byte_class = CLS_HEADER;
        trk_hdr_len = bump_len(trk_hdr_len);
        if (b == CHAR_CR) begin
          if (trk_lf <= 2'd1 && trk_cr < 2'd3) trk_cr = trk_cr + 2'd1;
        end else if (b == CHAR_LF) begin
          if ((trk_cr == 2'd1 || trk_cr == 2'd2) && trk_lf < 2'd3) trk_lf = trk_lf + 2'd1;
        end else begin
          trk_cr = '0;
          trk_lf = '0;
        end
        if (trk_cr == 2'd2 && trk_lf == 2'd2) begin
          trk_phase   = PH_PREFIX;
          trk_pfx_idx = '0;
        end
      end
      PH_PREFIX: begin
        if (trk_pfx_idx < PREFIX_LEN && b == open_char(trk_pfx_idx)) begin
          r.byte_class = CLS_PREFIX;
          trk_pfx_idx  = trk_pfx_idx + 3'd1;
          if (trk_pfx_idx >= PREFIX_LEN) begin
            trk_body   = 1'b1;
            trk_window = '0;
            trk_phase  = PH_BODY;
          end
        end else begin
          r.frame_complete = 1'b1;
          trk_phase        = PH_DONE;
        end
      end
      PH_BODY: begin
        r.byte_class = CLS_BODY;
        trk_body_len = bump_len(trk_body_len);
        trk_window   = {trk_window[55:0], b};
        if (trk_window == CLOSE_TAG) begin
          r.frame_complete = 1'b1;
          trk_phase        = PH_DONE;
        end
      end
      default: r.byte_class = CLS_OUTSIDE;
    endcase
    if (last) begin
      if (trk_phase == PH_PREFIX) r.frame_complete = 1'b1;
      total = trk_hdr_len;
      if (trk_body) total = total + PREFIX_LEN_COUNTED + trk_body_len;
      if (total > LEN_MAX) total = LEN_MAX;
      r.verdict_valid  = 1'b1;
      r.parse_ok       = (trk_phase == PH_PREFIX || trk_phase == PH_DONE);
      r.body_present   = trk_body;
      r.request_length = total[LEN_W-1:0];
      trk_phase    = PH_HEADER;
      trk_cr       = '0;
      trk_lf       = '0;
      trk_pfx_idx  = '0;
      trk_window   = '0;
      trk_hdr_len  = '0;
      trk_body_len = '0;
      trk_body     = 1'b0;
    end
    return r;
  endfunction

  function automatic void flag_mismatch(input string field, input int unsigned want,
                                        input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    error_count++;
  endfunction

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Handshake signals are stable mid-cycle; a beat seen here moves at the next edge.
  always @(negedge clk) begin : result_check
    beat_res_t got;
    beat_res_t want;
    beat_res_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {byte_class, frame_complete, verdict_valid, parse_ok, body_present,
               request_length};
        beats_checked++;
        if (got.verdict_valid === 1'b1) begin
          verdicts_seen++;
          if (got.parse_ok === 1'b1) verdicts_ok++;
          if (got.body_present === 1'b1) verdicts_body++;
        end
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, got);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.byte_class !== want.byte_class)
            flag_mismatch("byte_class", want.byte_class, got.byte_class);
          if (got.frame_complete !== want.frame_complete)
            flag_mismatch("frame_complete", want.frame_complete, got.frame_complete);
          if (got.verdict_valid !== want.verdict_valid)
            flag_mismatch("verdict_valid", want.verdict_valid, got.verdict_valid);
          if (got.parse_ok !== want.parse_ok)
            flag_mismatch("parse_ok", want.parse_ok, got.parse_ok);
          if (got.body_present !== want.body_present)
            flag_mismatch("body_present", want.body_present, got.body_present);
          if (got.request_length !== want.request_length)
            flag_mismatch("request_length", want.request_length, got.request_length);
        end
      end
      if (in_valid && !in_stall) begin
        pred = frame_tracker_step(data_byte, buffer_end);
        // tracker state still advances on rows with a typed-in result
        if (row_typed) pred = row_res;
        pending_results.push_back(pred);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("http_request_html_framer_core test failed");
        $finish;
      end
    end
  end

  // Offers one byte and returns at the edge that takes it.
  task automatic offer_beat(input logic [7:0] b, input logic last, input logic typed,
                            input beat_res_t tres);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    buffer_end <= last;
    row_typed  <= typed;
    row_res    <= tres;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_request();
    int unsigned i;
    for (i = 0; i < req_buf.size(); i++)
      offer_beat(req_buf[i], i == req_buf.size() - 1, 1'b0, NO_RES);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] text_char();
    if ($urandom_range(7) == 0) return 8'($urandom_range(255, 128));
    return 8'($urandom_range(126, 32));
  endfunction

  // Mostly well-formed requests with random content; some noise and truncation.
  task automatic build_request();
    int unsigned kind;
    int unsigned lines;
    int unsigned n;
    int unsigned k;
    int unsigned tail;
    int unsigned i;
    logic [7:0]  ch;
    req_buf.delete();
    kind = $urandom_range(99);
    if (kind < 15) begin
      n = $urandom_range(24, 1);
      repeat (n) begin
        case ($urandom_range(3))
          0:       req_buf.push_back(CHAR_CR);
          1:       req_buf.push_back(CHAR_LF);
          default: req_buf.push_back(8'($urandom_range(255)));
        endcase
      end
      return;
    end
    lines = $urandom_range(3);
    repeat (lines) begin
      n = $urandom_range(6, 1);
      repeat (n) req_buf.push_back(text_char());
      req_buf.push_back(CHAR_CR);
      req_buf.push_back(CHAR_LF);
    end
    if (lines == 0) begin
      req_buf.push_back(CHAR_CR);
      req_buf.push_back(CHAR_LF);
    end
    // a stray CR pushes the CR count past 2 and the header never closes
    if ($urandom_range(9) == 0) req_buf.push_back(CHAR_CR);
    req_buf.push_back(CHAR_CR);
    req_buf.push_back(CHAR_LF);
    tail = $urandom_range(9);
    if (tail == 1 || tail == 2) begin
      k = $urandom_range(6, (tail == 2) ? 1 : 0);
      for (i = 0; i < k; i++) req_buf.push_back(open_char(i));
      if (tail == 1) begin
        ch = 8'($urandom_range(255));
        if (ch == open_char(k)) ch = ch ^ 8'h01;
        req_buf.push_back(ch);
        repeat ($urandom_range(5)) req_buf.push_back(8'($urandom_range(255)));
      end
    end else if (tail >= 3) begin
      for (i = 0; i < PREFIX_LEN; i++) req_buf.push_back(open_char(i));
      n = $urandom_range(20);
      repeat (n) begin
        if ($urandom_range(3) == 0) begin
          k = $urandom_range(7, 1);
          for (i = 0; i < k; i++) req_buf.push_back(close_char(i));
        end else begin
          req_buf.push_back(text_char());
        end
      end
      if ($urandom_range(4) != 0) begin
        for (i = 0; i < 8; i++) req_buf.push_back(close_char(i));
        repeat ($urandom_range(4)) req_buf.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(req_buf.size(), 1);
      while (req_buf.size() > k) req_buf.delete(req_buf.size() - 1);
    end
  endtask

  initial begin
    int unsigned ph;
    int unsigned i;
    int unsigned phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 63; end
        default: begin send_idle_pct = 37; recv_stall_pct <= 37; end
      endcase
      phase_start = beats_sent;
      if (ph == 0) begin
        for (i = 0; i < DIR_ROW_COUNT; i++)
          offer_beat(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].typed,
                     DIR_ROWS[i].res);
        requests_sent += 3;
        drain_results();

        // receiver holds off while the sender keeps offering bytes
        hold_req <= hold_req + 1;
        phase_start = beats_sent;
        while (beats_sent - phase_start < HOLD_ITEMS) begin
          build_request();
          send_request();
        end
        drain_results();
        phase_start = beats_sent;
      end
      while (beats_sent - phase_start < PHASE_ITEMS) begin
        build_request();
        send_request();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d buffers under four idle/stall mixes.",
             beats_sent, requests_sent);
    $display("Checked %0d result beats, %0d verdicts (%0d ok, %0d with body).",
             beats_checked, verdicts_seen, verdicts_ok, verdicts_body);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("http_request_html_framer_core test passed");
    end else begin
      $display("http_request_html_framer_core test failed");
    end
    $finish;
  end

endmodule
